// ===== hw/rtl/wraps_pkg.sv =====
package wraps_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned OpW       = 2;
  localparam int unsigned DurW      = 30;
  localparam int unsigned McW       = 16;
  localparam int unsigned JobW      = 11;
  localparam int unsigned CntW      = 2;
  localparam int unsigned MachW     = 16;
  localparam int unsigned TimeW     = 40;
  localparam int unsigned MachCurW  = 17;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 112;
  localparam int unsigned OutFieldW = JobW + CntW + MachW + 2 * TimeW;

  // Divider operand widths: the rounded-up numerator needs one extra bit.
  localparam int unsigned NumW = TimeW + 1;

  // Default job capacity.
  localparam int unsigned MaxJobsDef = 1024;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EMIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_PUT
  } state_e;

  // One result beat before packing.
  typedef struct packed {
    logic             status;
    logic [JobW-1:0]  job_number;
    logic [CntW-1:0]  piece_count;
    logic [MachW-1:0] machine_number;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
    logic             last_piece;
  } res_t;

endpackage

// ===== hw/rtl/wraps_div.sv =====
module wraps_div #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CntBits = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [DEN_W-1:0]   rem_q;
  logic [DEN_W-1:0]   den_q;
  logic [NUM_W-1:0]   quo_q;

  logic [DEN_W:0]     shifted;
  logic               ge;
  logic [DEN_W:0]     diff;

  // One restoring step: bring in the next numerator bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    ge      = (shifted >= {1'b0, den_q});
    diff    = shifted - {1'b0, den_q};
  end

  // Sequencer: one quotient bit per cycle, MSB first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hw/rtl/wraps_store.sv =====
module wraps_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 30
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/wrap_around_preemptive_scheduler.sv =====
// Wrap-around preemptive scheduler.
// Input stream: s_axis_tuser carries the opcode (clear, load, emit, no-op) and
// s_axis_tdata carries the job duration for a load. Output stream: one or two
// beats per emit, each giving one piece of a job (job, piece count, machine,
// start and end time); tuser is the error status and tlast marks the final
// beat of an emit. The machine count is written through cfg_we_i/cfg_wdata_i.
// Clear, load and no-op produce no beat. An emit first reads the duration
// memory, then adds the duration to the machine fill level, and then
// compares against the makespan and launches the beats. The first emit
// after a clear that finds a job also runs the bit-serial divider that
// fixes the makespan; that divider produces one quotient bit per cycle over
// a 41-bit numerator.
// The output side has a main register and a second holding register, so the
// block keeps accepting loads while beats wait; a new emit holds in its last
// step until all earlier beats have left, and the input stalls meanwhile.
// Reset clears the job set, sets the machine count to one and empties the
// output; the duration memory needs no clearing.
module wrap_around_preemptive_scheduler #(
  parameter int unsigned MAX_JOBS = wraps_pkg::MaxJobsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wraps_pkg::McW-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // duration [29:0]
  input  logic [wraps_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [wraps_pkg::OpW-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // job_number [10:0], piece_count [12:11], machine_number [28:13],
  // start_time [68:29], end_time [108:69]
  output logic [wraps_pkg::OutDataW-1:0] m_axis_tdata,
  // status [0]
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  import wraps_pkg::*;

  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  state_e            st_q, st_d;
  logic [McW-1:0]    machine_count_q;
  logic [CW-1:0]     jobs_loaded_q;
  logic [CW-1:0]     jobs_emitted_q;
  logic [TimeW-1:0]  total_q;
  logic [DurW-1:0]   longest_q;
  logic [TimeW-1:0]  makespan_q;
  logic              ready_q;
  logic [TimeW-1:0]  fill_q;
  logic [MachCurW-1:0] mach_q;
  logic              err_q;
  logic [TimeW:0]    sum_q;

  res_t              out_q, hold_q;
  logic              out_valid_q, hold_valid_q;

  op_e               op;
  logic              in_acc, out_acc;
  logic              emit_none;
  logic              clr_en, ld_en, rd_en, div_start, put_en;
  logic [TimeW:0]    ld_sum;
  logic [DurW-1:0]   duration;
  logic [DurW-1:0]   rd_data;
  logic [McW-1:0]    m_eff;
  logic [NumW-1:0]   div_num;
  logic [NumW-1:0]   div_quot;
  logic              div_done;
  logic [TimeW-1:0]  makespan_new;
  logic [TimeW+1:0]  diff;
  logic              fits, exact;
  logic [JobW-1:0]   job_num;
  res_t              res_a, res_b;

  assign op       = op_e'(s_axis_tuser);
  assign duration = s_axis_tdata[DurW-1:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign emit_none = (jobs_emitted_q >= jobs_loaded_q);

  // Sequencer: next state and step strobes.
  always_comb begin
    st_d      = st_q;
    clr_en    = 1'b0;
    ld_en     = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    put_en    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_CLEAR: clr_en = 1'b1;
            OP_LOAD:  ld_en = !ready_q && (jobs_loaded_q < CW'(MAX_JOBS));
            OP_EMIT: begin
              if (emit_none) begin
                st_d = ST_PUT;
              end else begin
                rd_en = 1'b1;
                if (!ready_q) begin
                  div_start = 1'b1;
                  st_d      = ST_DIV;
                end else begin
                  st_d = ST_CALC;
                end
              end
            end
            OP_NOP: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_d = ST_CALC;
        end
      end
      ST_CALC: st_d = ST_PUT;
      ST_PUT: begin
        if (!out_valid_q) begin
          put_en = 1'b1;
          st_d   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Load accumulation with saturation of the total.
  assign ld_sum = {1'b0, total_q} + (TimeW + 1)'(duration);

  // Rounded-up numerator for the makespan division.
  assign m_eff   = (machine_count_q == '0) ? McW'(1) : machine_count_q;
  assign div_num = {1'b0, total_q} + NumW'(m_eff - McW'(1));

  assign makespan_new = (div_quot > NumW'(longest_q)) ? div_quot[TimeW-1:0]
                                                      : TimeW'(longest_q);

  // Piece placement: compare the new fill level against the makespan.
  always_comb begin
    diff    = {1'b0, sum_q} - {2'b00, makespan_q};
    exact   = (diff == '0);
    fits    = diff[TimeW+1] || exact;
    job_num = JobW'(CW'(jobs_emitted_q + CW'(1)));

    res_a = '0;
    res_b = '0;
    if (err_q) begin
      res_a.status     = 1'b1;
      res_a.last_piece = 1'b1;
    end else if (fits) begin
      res_a.job_number     = job_num;
      res_a.piece_count    = CntW'(1);
      res_a.machine_number = mach_q[MachW-1:0];
      res_a.start_time     = fill_q;
      res_a.end_time       = sum_q[TimeW-1:0];
      res_a.last_piece     = 1'b1;
    end else begin
      // Wrapped piece on the next machine goes out first.
      res_a.job_number     = job_num;
      res_a.piece_count    = CntW'(2);
      res_a.machine_number = MachW'(mach_q + MachCurW'(1));
      res_a.start_time     = '0;
      res_a.end_time       = diff[TimeW-1:0];
      res_a.last_piece     = 1'b0;
      res_b.job_number     = job_num;
      res_b.piece_count    = CntW'(2);
      res_b.machine_number = mach_q[MachW-1:0];
      res_b.start_time     = fill_q;
      res_b.end_time       = makespan_q;
      res_b.last_piece     = 1'b1;
    end
  end

  // Job set state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machine_count_q <= McW'(1);
      jobs_loaded_q   <= '0;
      jobs_emitted_q  <= '0;
      total_q         <= '0;
      longest_q       <= '0;
      makespan_q      <= '0;
      ready_q         <= 1'b0;
      fill_q          <= '0;
      mach_q          <= MachCurW'(1);
      err_q           <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        machine_count_q <= cfg_wdata_i;
      end
      if (in_acc && op == OP_EMIT) begin
        err_q <= emit_none;
      end
      if (clr_en) begin
        jobs_loaded_q  <= '0;
        jobs_emitted_q <= '0;
        total_q        <= '0;
        longest_q      <= '0;
        makespan_q     <= '0;
        ready_q        <= 1'b0;
        fill_q         <= '0;
        mach_q         <= MachCurW'(1);
      end else begin
        if (ld_en) begin
          jobs_loaded_q <= jobs_loaded_q + CW'(1);
          total_q       <= ld_sum[TimeW] ? '1 : ld_sum[TimeW-1:0];
          if (duration > longest_q) begin
            longest_q <= duration;
          end
        end
        if (st_q == ST_DIV && div_done) begin
          makespan_q <= makespan_new;
          ready_q    <= 1'b1;
          fill_q     <= '0;
          mach_q     <= MachCurW'(1);
        end
        if (put_en && !err_q) begin
          jobs_emitted_q <= jobs_emitted_q + CW'(1);
          if (fits) begin
            if (makespan_q != '0 && exact) begin
              mach_q <= mach_q + MachCurW'(1);
              fill_q <= '0;
            end else begin
              fill_q <= sum_q[TimeW-1:0];
            end
          end else begin
            mach_q <= mach_q + MachCurW'(1);
            fill_q <= diff[TimeW-1:0];
          end
        end
      end
    end
  end

  // Fill level plus the duration read from memory.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CALC) begin
      sum_q <= {1'b0, fill_q} + (TimeW + 1)'(rd_data);
    end
  end

  // Output register with one holding stage for the second piece.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else if (put_en) begin
      out_valid_q  <= 1'b1;
      hold_valid_q <= !err_q && !fits;
    end else if (out_acc) begin
      if (hold_valid_q) begin
        hold_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_en) begin
      out_q  <= res_a;
      hold_q <= res_b;
    end else if (out_acc && hold_valid_q) begin
      out_q <= hold_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutFieldW)'(0), out_q.end_time, out_q.start_time,
                          out_q.machine_number, out_q.piece_count, out_q.job_number};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last_piece;

  wraps_store #(
    .DEPTH (MAX_JOBS),
    .AW    (AW),
    .DW    (DurW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ld_en),
    .wr_addr_i (jobs_loaded_q[AW-1:0]),
    .wr_data_i (duration),
    .rd_en_i   (rd_en),
    .rd_addr_i (jobs_emitted_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  wraps_div #(
    .NUM_W (NumW),
    .DEN_W (McW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (m_eff),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // The second piece is only ever held behind a waiting first piece.
  a_hold_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("holding stage valid with empty output register");

  // Jobs are never emitted beyond those loaded.
  a_emit_le_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jobs_emitted_q <= jobs_loaded_q)
    else $error("emitted count passed loaded count");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == ST_DIV))
    else $error("divider finished outside its wait state");

  // Taking the first piece of a split moves the second one up.
  a_hold_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && hold_valid_q) |=> (out_valid_q && !hold_valid_q))
    else $error("held piece not forwarded");

endmodule

// ===== tb/wrap_around_preemptive_scheduler_test.sv =====
module wrap_around_preemptive_scheduler_test;
  import wraps_pkg::*;

  localparam int unsigned JOB_CAP = MaxJobsDef;
  localparam logic [DurW-1:0] DUR_MAX = '1;
  localparam longint unsigned TIME_MAX = 64'hFF_FFFF_FFFF;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;
  // The first emit of a set runs the divider plus three steps.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned STALL_CYCLES = 400;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    op_e              op;
    logic [DurW-1:0]  dur;
    logic [McW-1:0]   cfg_v;
    bit               typed;
    res_t             piece;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [McW-1:0]      cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = OP_NOP;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tlast;

  int unsigned send_idle_pct = 34;
  int unsigned rcv_idle_pct = 50;
  bit          stall_req = 1'b0;
  bit          rcv_hold = 1'b0;
  int unsigned err_count = 0;
  int unsigned beat_count = 0;

  // Pieces still owed by the block, oldest first.
  res_t     piece_q[$];
  dir_row_t dir_rows[$];
  res_t     nothing_left;

  // Scheduler state as the testbench tracks it.
  logic [DurW-1:0] job_dur [JOB_CAP];
  int unsigned     n_loaded;
  int unsigned     n_emitted;
  longint unsigned total_time;
  logic [DurW-1:0] longest_dur;
  longint unsigned span;
  bit              span_fixed;
  longint unsigned fill;
  int unsigned     cur_mach;
  logic [McW-1:0]  mach_count;

  wrap_around_preemptive_scheduler #(
    .MAX_JOBS(JOB_CAP)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 10-unit period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t make_piece(input logic status, input int unsigned job,
                                      input int unsigned cnt, input int unsigned mach,
                                      input longint unsigned t_start,
                                      input longint unsigned t_stop, input logic fin);
    res_t p;
    p.status         = status;
    p.job_number     = JobW'(job);
    p.piece_count    = CntW'(cnt);
    p.machine_number = MachW'(mach);
    p.start_time     = TimeW'(t_start);
    p.end_time       = TimeW'(t_stop);
    p.last_piece     = fin;
    return p;
  endfunction

  function automatic void clear_job_set();
    n_loaded    = 0;
    n_emitted   = 0;
    total_time  = 0;
    longest_dur = '0;
    span        = 0;
    span_fixed  = 1'b0;
    fill        = 0;
    cur_mach    = 1;
  endfunction

  // Applies one accepted item to the tracked state and returns the pieces it yields.
  function automatic int unsigned schedule_step(input op_e op, input logic [DurW-1:0] dur,
                                                output res_t p0, output res_t p1);
    longint unsigned m;
    longint unsigned quot;
    longint unsigned d;
    longint unsigned rest;
    p0 = '0;
    p1 = '0;
    case (op)
      OP_CLEAR: clear_job_set();
      OP_LOAD: begin
        if (!span_fixed && n_loaded < JOB_CAP) begin
          job_dur[n_loaded] = dur;
          n_loaded++;
          total_time += dur;
          if (total_time > TIME_MAX) total_time = TIME_MAX;
          if (dur > longest_dur) longest_dur = dur;
        end
      end
      OP_EMIT: begin
        if (n_emitted >= n_loaded) begin
          p0 = nothing_left;
          return 1;
        end
        // The makespan is fixed once per set, with a zero count read as one machine.
        if (!span_fixed) begin
          m = (mach_count == 0) ? 1 : mach_count;
          quot = (total_time + m - 1) / m;
          span = (quot > longest_dur) ? quot : longest_dur;
          span_fixed = 1'b1;
          fill = 0;
          cur_mach = 1;
        end
        d = job_dur[n_emitted];
        n_emitted++;
        if (fill + d <= span) begin
          p0 = make_piece(STATUS_OK, n_emitted, 1, cur_mach, fill, fill + d, 1'b1);
          fill += d;
          if (span != 0 && fill == span) begin
            cur_mach++;
            fill = 0;
          end
          return 1;
        end
        // Overflow: the wrapped piece on the next machine goes out first.
        rest = fill + d - span;
        p0 = make_piece(STATUS_OK, n_emitted, 2, cur_mach + 1, 0, rest, 1'b0);
        p1 = make_piece(STATUS_OK, n_emitted, 2, cur_mach, fill, span, 1'b1);
        cur_mach++;
        fill = rest;
        return 2;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic note_mismatch(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got_v,
                             input logic [63:0] want_v);
    if (got_v !== want_v)
      note_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                              beat_count, name, got_v, want_v));
  endtask

  // Compares one output beat with the oldest owed piece.
  task automatic check_beat();
    res_t seen;
    res_t want;
    seen.status         = m_axis_tuser[0];
    seen.job_number     = m_axis_tdata[10:0];
    seen.piece_count    = m_axis_tdata[12:11];
    seen.machine_number = m_axis_tdata[28:13];
    seen.start_time     = m_axis_tdata[68:29];
    seen.end_time       = m_axis_tdata[108:69];
    seen.last_piece     = m_axis_tlast;
    beat_count++;
    if (piece_q.size() == 0) begin
      note_mismatch($sformatf("beat %0d not owed: job %0d machine %0d",
                              beat_count, seen.job_number, seen.machine_number));
      return;
    end
    want = piece_q.pop_front();
    check_field("status", seen.status, want.status);
    check_field("job_number", seen.job_number, want.job_number);
    check_field("piece_count", seen.piece_count, want.piece_count);
    check_field("machine_number", seen.machine_number, want.machine_number);
    check_field("start_time", seen.start_time, want.start_time);
    check_field("end_time", seen.end_time, want.end_time);
    check_field("last_piece", seen.last_piece, want.last_piece);
  endtask

  // Output side: sample at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
  end

  // Receiver backpressure, changed at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // One long receiver hold-off, counted here, while the sender keeps offering.
  initial begin
    wait (stall_req);
    @(posedge clk_i);
    rcv_hold = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    rcv_hold = 1'b0;
  end

  // Offers one input beat, waits for its acceptance and records what it owes.
  task automatic send_item(input op_e op, input logic [DurW-1:0] dur,
                           input bit typed = 1'b0, input res_t typed_piece = '0);
    res_t        p0;
    res_t        p1;
    int unsigned n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InDataW'(dur);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = schedule_step(op, dur, p0, p1);
    if (typed) begin
      piece_q.push_back(typed_piece);
    end else begin
      if (n > 0) piece_q.push_back(p0);
      if (n > 1) piece_q.push_back(p1);
    end
    @(negedge clk_i);
  endtask

  // Register writes happen only with nothing owed and the block settled.
  task automatic write_machine_count(input logic [McW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (piece_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    mach_count = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_row(input row_kind_e kind, input op_e op,
                                  input logic [DurW-1:0] dur, input logic [McW-1:0] cfg_v,
                                  input bit typed, input res_t piece);
    dir_row_t r;
    r.kind  = kind;
    r.op    = op;
    r.dur   = dur;
    r.cfg_v = cfg_v;
    r.typed = typed;
    r.piece = piece;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [DurW-1:0] pick_duration(input int unsigned style);
    case (style)
      0: return DurW'($urandom_range(0, 15));
      1: return DurW'($urandom_range(0, 5000));
      2: return DurW'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return DUR_MAX;
          2: return DurW'($urandom());
          default: return DurW'($urandom_range(0, 15));
        endcase
      end
    endcase
  endfunction

  function automatic logic [McW-1:0] pick_machine_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return McW'($urandom());
      3: return McW'(1);
      default: return McW'($urandom_range(2, 8));
    endcase
  endfunction

  // Random job sets: mostly clear, loads, then emits, with some noise and broken sets.
  task automatic run_job_sets(input int unsigned target);
    int unsigned done_cnt;
    int unsigned n_jobs;
    int unsigned n_emits;
    int unsigned style;
    done_cnt = 0;
    while (done_cnt < target) begin
      if ($urandom_range(0, 6) == 0) write_machine_count(pick_machine_count());
      if ($urandom_range(0, 9) != 0) begin
        send_item(OP_CLEAR, DurW'($urandom()));
        done_cnt++;
      end
      n_jobs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 10);
      style = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n_jobs; i++) begin
        if (!span_fixed && n_loaded < JOB_CAP) done_cnt++;
        send_item(OP_LOAD, pick_duration(style));
      end
      n_emits = n_jobs + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) n_emits = $urandom_range(0, n_jobs);
      for (int unsigned i = 0; i < n_emits; i++) begin
        case ($urandom_range(0, 39))
          0: send_item(OP_NOP, DurW'($urandom()));
          1: send_item(OP_LOAD, pick_duration(style));
          2: write_machine_count(pick_machine_count());
          default: ;
        endcase
        send_item(OP_EMIT, DurW'($urandom()));
        done_cnt++;
      end
    end
  endtask

  // Run limit: well above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clear_job_set();
    mach_count = McW'(1);
    nothing_left = make_piece(STATUS_EMPTY, 0, 0, 0, 0, 0, 1'b1);

    // Directed rows; typed pieces are the ones plain from the rules.
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, nothing_left);
    add_row(ROW_ITEM, OP_NOP, DUR_MAX, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, 30'd5, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, 30'd3, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 1, 1, 1, 0, 5, 1'b1));
    // Ignored: the makespan is already fixed.
    add_row(ROW_ITEM, OP_LOAD, 30'd7, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 2, 1, 1, 5, 8, 1'b1));
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, nothing_left);
    add_row(ROW_ITEM, OP_CLEAR, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, DUR_MAX, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1,
            make_piece(STATUS_OK, 1, 1, 1, 0, DUR_MAX, 1'b1));
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 2, 1, 2, 0, 0, 1'b1));
    // A zero machine count acts as one machine.
    add_row(ROW_CFG, OP_NOP, '0, McW'(0), 0, '0);
    add_row(ROW_ITEM, OP_CLEAR, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, 30'd4, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, 30'd4, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 1, 1, 1, 0, 4, 1'b1));
    // A count change mid-set waits for the next clear.
    add_row(ROW_CFG, OP_NOP, '0, McW'(3), 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 2, 1, 1, 4, 8, 1'b1));
    add_row(ROW_ITEM, OP_CLEAR, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, 30'd3, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, 30'd4, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 0, '0);
    // All durations zero: zero makespan, no machine advance.
    add_row(ROW_CFG, OP_NOP, '0, McW'(16'hFFFF), 0, '0);
    add_row(ROW_ITEM, OP_CLEAR, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_LOAD, '0, '0, 0, '0);
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 1, 1, 1, 0, 0, 1'b1));
    add_row(ROW_ITEM, OP_EMIT, '0, '0, 1, make_piece(STATUS_OK, 2, 1, 1, 0, 0, 1'b1));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_machine_count(dir_rows[i].cfg_v);
      else send_item(dir_rows[i].op, dir_rows[i].dur, dir_rows[i].typed, dir_rows[i].piece);
    end

    run_job_sets(150);
    send_idle_pct = 50;
    rcv_idle_pct = 34;
    run_job_sets(150);
    send_idle_pct = 0;
    rcv_idle_pct = 0;

    // Receiver holds off while emits keep coming, so the input side stalls.
    write_machine_count(McW'(3));
    stall_req = 1'b1;
    send_item(OP_CLEAR, '0);
    for (int unsigned i = 0; i < 16; i++) send_item(OP_LOAD, pick_duration(0));
    for (int unsigned i = 0; i < 24; i++) send_item(OP_EMIT, '0);

    // Full job store: loads past capacity must not reach the makespan.
    write_machine_count(McW'(512));
    send_item(OP_CLEAR, '0);
    for (int unsigned i = 0; i < JOB_CAP; i++) send_item(OP_LOAD, DurW'($urandom_range(1, 100)));
    for (int unsigned i = 0; i < 4; i++) send_item(OP_LOAD, DUR_MAX);
    for (int unsigned i = 0; i < 40; i++) send_item(OP_EMIT, '0);

    run_job_sets(60);

    s_axis_tvalid <= 1'b0;
    while (piece_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
